>>> hw/rtl/assert_macros.svh
// assertion macros shared by the tween table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ett_pkg.sv
// package for the eased tween table: codes, constants and shared types
`default_nettype none
package ett_pkg;

    localparam int MAX_TWEENS_DEFAULT  = 16;
    localparam int SINE_ENTRIES_DEFAULT = 256;
    localparam int FIFO_DEPTH          = 2;

    localparam logic [2:0] CMD_TICK       = 3'd0;
    localparam logic [2:0] CMD_START      = 3'd1;
    localparam logic [2:0] CMD_CANCEL     = 3'd2;
    localparam logic [2:0] CMD_CANCEL_ALL = 3'd3;
    localparam logic [2:0] CMD_CLEAR      = 3'd4;
    localparam logic [2:0] CMD_INIT       = 3'd5;

    localparam logic [3:0] EASE_LINEAR      = 4'd0;
    localparam logic [3:0] EASE_QUAD_IN     = 4'd1;
    localparam logic [3:0] EASE_QUAD_OUT    = 4'd2;
    localparam logic [3:0] EASE_QUAD_INOUT  = 4'd3;
    localparam logic [3:0] EASE_CUBIC_IN    = 4'd4;
    localparam logic [3:0] EASE_CUBIC_OUT   = 4'd5;
    localparam logic [3:0] EASE_CUBIC_INOUT = 4'd6;
    localparam logic [3:0] EASE_SINE_IN     = 4'd7;
    localparam logic [3:0] EASE_SINE_OUT    = 4'd8;
    localparam logic [3:0] EASE_SINE_INOUT  = 4'd9;

    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [16:0] HALF_Q16    = 17'd32768;
    localparam logic [23:0] ELAPSED_MAX = 24'hFFFFFF;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] delta;
        logic [31:0] from_value;
        logic [31:0] to_value;
        logic [23:0] span;
        logic [3:0]  ease_mode;
        logic [15:0] target_id;
    } t_cmd;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] from_value;
        logic [31:0] to_value;
        logic [23:0] span;
        logic [23:0] elapsed;
        logic [3:0]  mode;
    } t_slot;

endpackage
`default_nettype wire

>>> hw/rtl/ett_front.sv
// front end: takes command transactions, drops unused codes, queues the rest
`default_nettype none
`include "assert_macros.svh"
module ett_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_valid,
    output logic               o_s_ready,
    input  wire ett_pkg::t_cmd i_cmd,
    output logic               o_q_valid,
    input  wire logic          i_q_ready,
    output ett_pkg::t_cmd      o_q_cmd
);
    localparam int PTR_W = (ett_pkg::FIFO_DEPTH > 1) ? $clog2(ett_pkg::FIFO_DEPTH) : 1;
    localparam int FILL_W = $clog2(ett_pkg::FIFO_DEPTH + 1);

    ett_pkg::t_cmd r_mem [ett_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic w_push, w_pop, w_known;

    assign w_known   = (i_cmd.command <= ett_pkg::CMD_INIT);
    assign o_s_ready = (r_fill != FILL_W'(ett_pkg::FIFO_DEPTH));
    assign w_push    = i_s_valid && o_s_ready && w_known;
    assign o_q_valid = (r_fill != '0);
    assign w_pop     = o_q_valid && i_q_ready;
    assign o_q_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(ett_pkg::FIFO_DEPTH - 1)) ? '0
                                                                         : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(ett_pkg::FIFO_DEPTH - 1)) ? '0
                                                                         : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    `ASSERT_CLK(a_fill_bound, (r_fill <= FILL_W'(ett_pkg::FIFO_DEPTH)), "queue overfilled")
endmodule
`default_nettype wire

>>> hw/rtl/ett_slot_ram.sv
// slot memory: one write port, one registered read port
`default_nettype none
module ett_slot_ram #(
    parameter int DEPTH = ett_pkg::MAX_TWEENS_DEFAULT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire ett_pkg::t_slot                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output ett_pkg::t_slot                           o_rdata
);
    ett_pkg::t_slot r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/ett_back.sv
// back end: command sequencer, progress divider, easing datapath and result register
`default_nettype none
`include "assert_macros.svh"
module ett_back #(
    parameter int MAX_TWEENS         = ett_pkg::MAX_TWEENS_DEFAULT,
    parameter int SINE_TABLE_ENTRIES = ett_pkg::SINE_ENTRIES_DEFAULT
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_ready,
    input  wire ett_pkg::t_cmd i_cmd,
    output logic               o_ram_we,
    output logic [(MAX_TWEENS > 1 ? $clog2(MAX_TWEENS) : 1)-1:0] o_ram_waddr,
    output ett_pkg::t_slot     o_ram_wdata,
    output logic [(MAX_TWEENS > 1 ? $clog2(MAX_TWEENS) : 1)-1:0] o_ram_raddr,
    input  wire ett_pkg::t_slot i_ram_rdata,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic               o_m_kind,
    output logic [15:0]        o_m_tid,
    output logic [31:0]        o_m_value,
    output logic               o_m_complete,
    output logic               o_m_table_full,
    output logic               o_m_tlast
);
    localparam int IDX_W   = (MAX_TWEENS > 1) ? $clog2(MAX_TWEENS) : 1;
    localparam int CNT_W   = $clog2(MAX_TWEENS + 1);
    localparam int ROM_AW  = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int KP_W    = 18 + ROM_AW;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ACK  = 4'd1;
    localparam logic [3:0] ST_SCAN = 4'd2;
    localparam logic [3:0] ST_LOAD = 4'd3;
    localparam logic [3:0] ST_DIV  = 4'd4;
    localparam logic [3:0] ST_MUL1 = 4'd5;
    localparam logic [3:0] ST_MUL2 = 4'd6;
    localparam logic [3:0] ST_EASE = 4'd7;
    localparam logic [3:0] ST_MULV = 4'd8;
    localparam logic [3:0] ST_EMIT = 4'd9;
    localparam logic [3:0] ST_CRD  = 4'd10;
    localparam logic [3:0] ST_CCMP = 4'd11;

    typedef logic [16:0] t_rom [SINE_TABLE_ENTRIES + 1];

    function automatic t_rom sine_build();
        t_rom rom;
        logic [63:0] x, x2, term;
        logic signed [63:0] sum;
        for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
            x    = (64'(k) * ett_pkg::HALF_PI_Q30) / SINE_TABLE_ENTRIES;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            term = ((term * x2) >> 30) / 6;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 20;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 42;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 72;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 110;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 156;
            sum  = sum + $signed(term);
            if (sum < 0) begin
                sum = 0;
            end
            sum = (sum + 64'sd8192) >>> 14;
            if (sum > 64'sd65536) begin
                sum = 64'sd65536;
            end
            rom[k] = sum[16:0];
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = sine_build();

    logic [3:0]            r_state;
    ett_pkg::t_cmd         r_cmd;
    logic [CNT_W-1:0]      r_count, r_idx, r_wr;
    logic [MAX_TWEENS-1:0] r_cancel;
    logic [15:0]           r_next_id;
    ett_pkg::t_slot        r_slot;
    logic [23:0]           r_el, r_rem;
    logic [15:0]           r_q;
    logic [3:0]            r_bit;
    logic [16:0]           r_u, r_eased, r_rom;
    logic                  r_sine_hi;
    logic signed [52:0]    r_prod;

    logic r_out_valid, r_o_kind, r_o_complete, r_o_full, r_o_last;
    logic [15:0] r_o_id;
    logic [31:0] r_o_value;

    logic               w_out_free, w_full, w_done, w_later, w_cubic;
    logic [24:0]        w_el_sum, w_rem2;
    logic [23:0]        w_el;
    logic [16:0]        w_g, w_b, w_eased;
    logic [17:0]        w_half_sum;
    logic signed [32:0] w_diff;
    logic signed [34:0] w_mul_a;
    logic signed [17:0] w_mul_b;
    logic signed [52:0] w_mul_p;
    logic [KP_W-1:0]    w_kprod;
    logic [ROM_AW-1:0]  w_k, w_rom_addr;
    logic [ROM_AW:0]    w_m;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_full     = (r_count == CNT_W'(MAX_TWEENS));
    assign w_done     = (r_u == ett_pkg::ONE_Q16);
    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_ram_raddr = r_idx[IDX_W-1:0];

    assign w_el_sum = {1'b0, i_ram_rdata.elapsed} + {9'd0, r_cmd.delta};
    assign w_el     = w_el_sum[24] ? ett_pkg::ELAPSED_MAX : w_el_sum[23:0];
    assign w_rem2   = {r_rem, 1'b0};
    assign w_g      = ett_pkg::ONE_Q16 - r_u;
    assign w_diff   = {r_slot.to_value[31], r_slot.to_value}
                    - {r_slot.from_value[31], r_slot.from_value};
    assign w_cubic  = (r_slot.mode == ett_pkg::EASE_CUBIC_IN)
                   || (r_slot.mode == ett_pkg::EASE_CUBIC_OUT)
                   || (r_slot.mode == ett_pkg::EASE_CUBIC_INOUT);

    always_comb begin
        case (r_slot.mode)
            ett_pkg::EASE_CUBIC_IN:  w_b = r_u;
            ett_pkg::EASE_CUBIC_OUT: w_b = w_g;
            default:                 w_b = (r_u < ett_pkg::HALF_Q16) ? r_u : w_g;
        endcase
    end

    // sine table index
    assign w_kprod = KP_W'(r_u) * KP_W'(SINE_TABLE_ENTRIES);
    assign w_k     = w_kprod[16 +: ROM_AW];
    assign w_m     = w_kprod[15 +: ROM_AW + 1];
    always_comb begin
        case (r_slot.mode)
            ett_pkg::EASE_SINE_IN:  w_rom_addr = ROM_AW'(SINE_TABLE_ENTRIES) - w_k;
            ett_pkg::EASE_SINE_OUT: w_rom_addr = w_k;
            default: begin
                if (w_m > (ROM_AW + 1)'(SINE_TABLE_ENTRIES)) begin
                    w_rom_addr = ROM_AW'(w_m - (ROM_AW + 1)'(SINE_TABLE_ENTRIES));
                end else begin
                    w_rom_addr = ROM_AW'((ROM_AW + 1)'(SINE_TABLE_ENTRIES) - w_m);
                end
            end
        endcase
    end

    // shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = $signed({1'b0, r_u});
        case (r_state)
            ST_MUL1: begin
                case (r_slot.mode)
                    ett_pkg::EASE_QUAD_IN:  w_mul_a = $signed(35'(r_u));
                    ett_pkg::EASE_QUAD_OUT: w_mul_a = $signed(35'(18'd131072 - 18'(r_u)));
                    ett_pkg::EASE_QUAD_INOUT: begin
                        if (r_u < ett_pkg::HALF_Q16) begin
                            w_mul_a = $signed(35'({r_u, 1'b0}));
                        end else begin
                            w_mul_a = $signed(35'(19'd262144 - {1'b0, r_u, 1'b0}));
                        end
                    end
                    default: begin
                        w_mul_a = $signed(35'(w_b));
                        w_mul_b = $signed({1'b0, w_b});
                    end
                endcase
            end
            ST_MUL2: begin
                w_mul_a = $signed({1'b0, r_prod[33:0]});
                w_mul_b = $signed({1'b0, w_b});
            end
            ST_MULV: begin
                w_mul_a = $signed({{2{w_diff[32]}}, w_diff});
                w_mul_b = $signed({1'b0, r_eased});
            end
            default: begin
                w_mul_a = '0;
            end
        endcase
        w_mul_p = w_mul_a * w_mul_b;
    end

    always_comb begin
        w_half_sum = r_sine_hi ? (18'(ett_pkg::ONE_Q16) + 18'(r_rom))
                               : (18'(ett_pkg::ONE_Q16) - 18'(r_rom));
        case (r_slot.mode)
            ett_pkg::EASE_QUAD_IN, ett_pkg::EASE_QUAD_OUT: w_eased = r_prod[32:16];
            ett_pkg::EASE_QUAD_INOUT: begin
                if (r_u < ett_pkg::HALF_Q16) begin
                    w_eased = r_prod[32:16];
                end else begin
                    w_eased = 17'(r_prod[33:16] - 18'(ett_pkg::ONE_Q16));
                end
            end
            ett_pkg::EASE_CUBIC_IN:  w_eased = r_prod[48:32];
            ett_pkg::EASE_CUBIC_OUT: w_eased = ett_pkg::ONE_Q16 - r_prod[48:32];
            ett_pkg::EASE_CUBIC_INOUT: begin
                if (r_u < ett_pkg::HALF_Q16) begin
                    w_eased = r_prod[46:30];
                end else begin
                    w_eased = ett_pkg::ONE_Q16 - r_prod[46:30];
                end
            end
            ett_pkg::EASE_SINE_IN:    w_eased = ett_pkg::ONE_Q16 - r_rom;
            ett_pkg::EASE_SINE_OUT:   w_eased = r_rom;
            ett_pkg::EASE_SINE_INOUT: w_eased = w_half_sum[17:1];
            default:                  w_eased = r_u;
        endcase
    end

    // any live slot after the current one
    always_comb begin
        w_later = 1'b0;
        for (int j = 0; j < MAX_TWEENS; j++) begin
            if (CNT_W'(j) > r_idx && CNT_W'(j) < r_count && !r_cancel[j]) begin
                w_later = 1'b1;
            end
        end
    end

    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = r_wr[IDX_W-1:0];
        o_ram_wdata = r_slot;
        o_ram_wdata.elapsed = r_el;
        if (r_state == ST_ACK) begin
            o_ram_we    = w_out_free && !w_full;
            o_ram_waddr = r_count[IDX_W-1:0];
            o_ram_wdata.id         = r_next_id;
            o_ram_wdata.from_value = r_cmd.from_value;
            o_ram_wdata.to_value   = r_cmd.to_value;
            o_ram_wdata.span       = r_cmd.span;
            o_ram_wdata.elapsed    = '0;
            o_ram_wdata.mode       = r_cmd.ease_mode;
        end else if (r_state == ST_EMIT) begin
            o_ram_we = w_out_free && !w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_LOAD: begin
                r_slot <= i_ram_rdata;
                r_el   <= w_el;
                r_rem  <= w_el;
                r_q    <= '0;
                r_bit  <= '0;
                if (i_ram_rdata.span == '0 || w_el >= i_ram_rdata.span) begin
                    r_u <= ett_pkg::ONE_Q16;
                end
            end
            ST_DIV: begin
                r_bit <= r_bit + 1'b1;
                if (w_rem2 >= {1'b0, r_slot.span}) begin
                    r_rem <= 24'(w_rem2 - {1'b0, r_slot.span});
                    r_q   <= {r_q[14:0], 1'b1};
                    r_u   <= {1'b0, r_q[14:0], 1'b1};
                end else begin
                    r_rem <= w_rem2[23:0];
                    r_q   <= {r_q[14:0], 1'b0};
                    r_u   <= {1'b0, r_q[14:0], 1'b0};
                end
            end
            ST_MUL1: begin
                r_prod    <= w_mul_p;
                r_rom     <= SINE_ROM[w_rom_addr];
                r_sine_hi <= (w_m > (ROM_AW + 1)'(SINE_TABLE_ENTRIES));
            end
            ST_MUL2: begin
                if (w_cubic) begin
                    r_prod <= w_mul_p;
                end
            end
            ST_EASE: r_eased <= w_eased;
            ST_MULV: r_prod  <= w_mul_p;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_cmd_valid) begin
            r_cmd <= i_cmd;
        end
        if (r_state == ST_ACK && w_out_free) begin
            r_o_kind     <= ett_pkg::KIND_ACK;
            r_o_id       <= w_full ? 16'd0 : r_next_id;
            r_o_value    <= '0;
            r_o_complete <= 1'b0;
            r_o_full     <= w_full;
            r_o_last     <= 1'b1;
        end else if (r_state == ST_EMIT && w_out_free) begin
            r_o_kind     <= ett_pkg::KIND_UPDATE;
            r_o_id       <= r_slot.id;
            r_o_value    <= r_slot.from_value + r_prod[47:16];
            r_o_complete <= w_done;
            r_o_full     <= 1'b0;
            r_o_last     <= !w_later;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_wr        <= '0;
            r_next_id   <= 16'd1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_m_tready && !((r_state == ST_ACK || r_state == ST_EMIT) && w_out_free)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_idx <= '0;
                        r_wr  <= '0;
                        case (i_cmd.command)
                            ett_pkg::CMD_TICK:       r_state  <= ST_SCAN;
                            ett_pkg::CMD_START:      r_state  <= ST_ACK;
                            ett_pkg::CMD_CANCEL:     r_state  <= ST_CRD;
                            ett_pkg::CMD_CANCEL_ALL: r_cancel <= '1;
                            ett_pkg::CMD_CLEAR:      r_count  <= '0;
                            ett_pkg::CMD_INIT: begin
                                r_count   <= '0;
                                r_next_id <= 16'd1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_ACK: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        if (!w_full) begin
                            r_cancel[r_count[IDX_W-1:0]] <= 1'b0;
                            r_count   <= r_count + 1'b1;
                            r_next_id <= r_next_id + 16'd1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_SCAN: begin
                    if (r_idx >= r_count) begin
                        r_count  <= r_wr;
                        r_cancel <= '0;
                        r_state  <= ST_IDLE;
                    end else if (r_cancel[r_idx[IDX_W-1:0]]) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (i_ram_rdata.span == '0 || w_el >= i_ram_rdata.span) begin
                        r_state <= ST_MUL1;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_bit == 4'd15) begin
                        r_state <= ST_MUL1;
                    end
                end
                ST_MUL1: r_state <= ST_MUL2;
                ST_MUL2: r_state <= ST_EASE;
                ST_EASE: r_state <= ST_MULV;
                ST_MULV: r_state <= ST_EMIT;
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        if (!w_done) begin
                            r_wr <= r_wr + 1'b1;
                        end
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_SCAN;
                    end
                end
                ST_CRD: begin
                    if (r_idx >= r_count) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_CCMP;
                    end
                end
                ST_CCMP: begin
                    if (i_ram_rdata.id == r_cmd.target_id) begin
                        r_cancel[r_idx[IDX_W-1:0]] <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_CRD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid     = r_out_valid;
    assign o_m_kind       = r_o_kind;
    assign o_m_tid        = r_o_id;
    assign o_m_value      = r_o_value;
    assign o_m_complete   = r_o_complete;
    assign o_m_table_full = r_o_full;
    assign o_m_tlast      = r_o_last;

    `ASSERT_CLK(a_count_bound, (r_count <= CNT_W'(MAX_TWEENS)), "slot count beyond table")
    `ASSERT_IMPL(a_compact_order, (r_state == ST_EMIT), (r_wr <= r_idx), "write ahead of read")
    `ASSERT_NEXT(a_start_grows, (r_state == ST_ACK && w_out_free && !w_full), (r_count == $past(r_count) + CNT_W'(1)), "start did not take a slot")
endmodule
`default_nettype wire

>>> hw/rtl/eased_tween_table.sv
// top level of the eased tween table
// Commands enter a two-deep queue and run one at a time against a table of
// up to MAX_TWEENS tweens held in a slot memory. A tick passes over cancelled
// slots; for a live one still short of its span, progress comes from the
// 16-step restoring divider, and the single shared multiplier evaluates the
// easing curve and the interpolation. Results wait in an output register while
// the queue keeps taking commands. There is no clearing pass after reset.
`default_nettype none
module eased_tween_table #(
    parameter int MAX_TWEENS         = ett_pkg::MAX_TWEENS_DEFAULT,
    parameter int SINE_TABLE_ENTRIES = ett_pkg::SINE_ENTRIES_DEFAULT
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // delta, from value, to value, span, ease_mode, target_id, zero pad
    input  wire logic [127:0] i_s_tdata,
    // command
    input  wire logic [2:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // id, value, complete, table_full, zero pad
    output logic [55:0]       o_m_tdata,
    // kind
    output logic [0:0]        o_m_tuser,
    output logic              o_m_tlast
);
    localparam int IDX_W = (MAX_TWEENS > 1) ? $clog2(MAX_TWEENS) : 1;

    ett_pkg::t_cmd  w_in_cmd, w_q_cmd;
    ett_pkg::t_slot w_wdata, w_rdata;
    logic w_q_valid, w_q_ready, w_we;
    logic [IDX_W-1:0] w_waddr, w_raddr;
    logic [15:0] w_id;
    logic [31:0] w_value;
    logic w_complete, w_full, w_kind;

    assign w_in_cmd.command    = i_s_tuser;
    assign w_in_cmd.delta      = i_s_tdata[15:0];
    assign w_in_cmd.from_value = i_s_tdata[47:16];
    assign w_in_cmd.to_value   = i_s_tdata[79:48];
    assign w_in_cmd.span       = i_s_tdata[103:80];
    assign w_in_cmd.ease_mode  = i_s_tdata[107:104];
    assign w_in_cmd.target_id  = i_s_tdata[123:108];

    ett_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .o_s_ready (o_s_tready),
        .i_cmd     (w_in_cmd),
        .o_q_valid (w_q_valid),
        .i_q_ready (w_q_ready),
        .o_q_cmd   (w_q_cmd)
    );

    ett_slot_ram #(.DEPTH(MAX_TWEENS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ett_back #(
        .MAX_TWEENS         (MAX_TWEENS),
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_q_valid),
        .o_cmd_ready    (w_q_ready),
        .i_cmd          (w_q_cmd),
        .o_ram_we       (w_we),
        .o_ram_waddr    (w_waddr),
        .o_ram_wdata    (w_wdata),
        .o_ram_raddr    (w_raddr),
        .i_ram_rdata    (w_rdata),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_m_kind       (w_kind),
        .o_m_tid        (w_id),
        .o_m_value      (w_value),
        .o_m_complete   (w_complete),
        .o_m_table_full (w_full),
        .o_m_tlast      (o_m_tlast)
    );

    assign o_m_tdata = {6'd0, w_full, w_complete, w_value, w_id};
    assign o_m_tuser = w_kind;
endmodule
`default_nettype wire

>>> tb/eased_tween_table_test.sv
// self-checking testbench for the eased tween table: stream stimulus, prediction and checks
`default_nettype none
module eased_tween_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]  cmd;
        logic [15:0] delta;
        logic [31:0] sv;
        logic [31:0] ev;
        logic [23:0] span;
        logic [3:0]  mode;
        logic [15:0] tid;
    } t_order;

    typedef struct {
        logic        kind;
        logic [15:0] id;
        logic [31:0] value;
        logic        comp;
        logic        full;
        logic        last;
    } t_event;

    localparam int NSLOT = 16;
    localparam int NSINE = 256;
    localparam int CYCLE_LIMIT = 400000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [127:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tready = 1'b0;
    logic         s_tready;
    logic         m_tvalid;
    logic [55:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;

    t_order orders[$];
    t_event expected_events[$];
    t_order in_flight;
    int     errors = 0;
    int     sent = 0;
    int     hold_at = -1;
    int     hold_left = 0;
    bit     hold_done = 1'b0;
    int     src_gap = 0;
    int     dst_gap = 0;
    int     cycles = 0;
    bit     calm;

    // tween table mirror
    bit          tw_valid[NSLOT];
    bit          tw_cancel[NSLOT];
    logic [15:0] tw_id[NSLOT];
    logic [31:0] tw_start[NSLOT];
    logic [31:0] tw_end[NSLOT];
    logic [23:0] tw_span[NSLOT];
    logic [23:0] tw_elapsed[NSLOT];
    logic [3:0]  tw_mode[NSLOT];
    logic [15:0] id_next = 16'd1;

    eased_tween_table u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    assign calm = (orders.size() < 25);

    task automatic enqueue(t_order o);
        orders.insert(orders.size(), o);
    endtask

    task automatic predict(t_event e);
        expected_events.insert(expected_events.size(), e);
    endtask

    function automatic longint unsigned sine_q16(longint unsigned k);
        longint unsigned x, x2, term;
        longint          acc;
        if (k > NSINE) k = NSINE;
        x = (k * 64'd1686629713) / NSINE;
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        acc = (acc + 8192) >>> 14;
        if (acc > 65536) acc = 65536;
        return longint'(acc);
    endfunction

    function automatic longint unsigned eased(longint unsigned u, logic [3:0] mode);
        longint unsigned g, k, m;
        g = 65536 - u;
        k = (u * NSINE) >> 16;
        m = (2 * u * NSINE) >> 16;
        case (mode)
            ett_pkg::EASE_QUAD_IN: return (u * u) >> 16;
            ett_pkg::EASE_QUAD_OUT: return (u * (131072 - u)) >> 16;
            ett_pkg::EASE_QUAD_INOUT: begin
                if (u < 32768) return (2 * u * u) >> 16;
                return ((u * (262144 - 2 * u)) >> 16) - 65536;
            end
            ett_pkg::EASE_CUBIC_IN: return (u * u * u) >> 32;
            ett_pkg::EASE_CUBIC_OUT: return 65536 - ((g * g * g) >> 32);
            ett_pkg::EASE_CUBIC_INOUT: begin
                if (u < 32768) return (4 * u * u * u) >> 32;
                return 65536 - ((4 * g * g * g) >> 32);
            end
            ett_pkg::EASE_SINE_IN: return 65536 - sine_q16(NSINE - k);
            ett_pkg::EASE_SINE_OUT: return sine_q16(k);
            ett_pkg::EASE_SINE_INOUT: begin
                if (m <= NSINE) return (65536 - sine_q16(NSINE - m)) >> 1;
                return (65536 + sine_q16(m - NSINE)) >> 1;
            end
            default: return u;
        endcase
    endfunction

    task automatic advance_tweens(logic [15:0] delta);
        int              w;
        longint unsigned el, p;
        longint          diff, step;
        bit              done;
        t_event          e;
        w = 0;
        for (int i = 0; i < NSLOT; i++) begin
            if (!tw_valid[i]) continue;
            tw_valid[i] = 1'b0;
            if (tw_cancel[i]) continue;
            el = longint'(tw_elapsed[i]) + longint'(delta);
            if (el > 64'hFFFFFF) el = 64'hFFFFFF;
            tw_elapsed[i] = el[23:0];
            if (tw_span[i] == 0) p = 65536;
            else begin
                p = (el << 16) / longint'(tw_span[i]);
                if (p > 65536) p = 65536;
            end
            done = (p >= 65536);
            diff = longint'(signed'(tw_end[i])) - longint'(signed'(tw_start[i]));
            step = (diff * longint'(eased(p, tw_mode[i]))) >>> 16;
            e.kind = ett_pkg::KIND_UPDATE;
            e.id = tw_id[i];
            e.value = 32'(longint'(signed'(tw_start[i])) + step);
            e.comp = done;
            e.full = 1'b0;
            e.last = 1'b0;
            predict(e);
            if (!done) begin
                tw_valid[w] = 1'b1;
                tw_id[w] = tw_id[i];
                tw_start[w] = tw_start[i];
                tw_end[w] = tw_end[i];
                tw_span[w] = tw_span[i];
                tw_elapsed[w] = tw_elapsed[i];
                tw_mode[w] = tw_mode[i];
                tw_cancel[w] = 1'b0;
                w++;
            end
        end
    endtask

    task automatic apply_order(t_order o);
        int     prior, live;
        t_event e;
        prior = expected_events.size();
        case (o.cmd)
            ett_pkg::CMD_TICK: advance_tweens(o.delta);
            ett_pkg::CMD_START: begin
                live = 0;
                foreach (tw_valid[i]) if (tw_valid[i]) live++;
                e = '{ett_pkg::KIND_ACK, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0};
                if (live >= NSLOT) e.full = 1'b1;
                else begin
                    tw_valid[live] = 1'b1;
                    tw_cancel[live] = 1'b0;
                    tw_id[live] = id_next;
                    tw_start[live] = o.sv;
                    tw_end[live] = o.ev;
                    tw_span[live] = o.span;
                    tw_elapsed[live] = '0;
                    tw_mode[live] = o.mode;
                    e.id = id_next;
                    id_next = id_next + 16'd1;
                end
                predict(e);
            end
            ett_pkg::CMD_CANCEL: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (tw_valid[i] && tw_id[i] == o.tid) begin
                        tw_cancel[i] = 1'b1;
                        break;
                    end
                end
            end
            ett_pkg::CMD_CANCEL_ALL:
                foreach (tw_valid[i]) if (tw_valid[i]) tw_cancel[i] = 1'b1;
            ett_pkg::CMD_CLEAR: foreach (tw_valid[i]) tw_valid[i] = 1'b0;
            ett_pkg::CMD_INIT: begin
                foreach (tw_valid[i]) tw_valid[i] = 1'b0;
                id_next = 16'd1;
            end
            default: ;
        endcase
        if (expected_events.size() > prior)
            expected_events[expected_events.size() - 1].last = 1'b1;
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // stimulus driver
    always @(posedge i_clk) begin
        bit nv;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            nv = s_tvalid;
            if (s_tvalid && s_tready) begin
                apply_order(in_flight);
                sent++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (orders.size() > 0) begin
                    in_flight = orders.pop_front();
                    s_tdata <= {4'b0, in_flight.tid, in_flight.mode, in_flight.span,
                                in_flight.ev, in_flight.sv, in_flight.delta};
                    s_tuser <= in_flight.cmd;
                    nv = 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 3);
                end
            end
            s_tvalid <= nv;
        end
    end

    // long receiver hold-off so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && hold_at >= 0 && sent >= hold_at) begin
            hold_done <= 1'b1;
            hold_left <= 3000;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_event want;
        bit     rdy;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    report("unexpected transaction", 64'(m_tdata), '0);
                end else begin
                    want = expected_events.pop_front();
                    if (m_tuser[0] !== want.kind)
                        report("kind", 64'(m_tuser), 64'(want.kind));
                    if (m_tdata[15:0] !== want.id)
                        report("id", 64'(m_tdata[15:0]), 64'(want.id));
                    if (m_tdata[47:16] !== want.value)
                        report("value", 64'(m_tdata[47:16]), 64'(want.value));
                    if (m_tdata[48] !== want.comp)
                        report("complete", 64'(m_tdata[48]), 64'(want.comp));
                    if (m_tdata[49] !== want.full)
                        report("table_full", 64'(m_tdata[49]), 64'(want.full));
                    if (m_tlast !== want.last)
                        report("last", 64'(m_tlast), 64'(want.last));
                end
            end
            rdy = 1'b1;
            if (hold_left > 1 || (!hold_done && hold_at >= 0 && sent >= hold_at)) rdy = 1'b0;
            else if (dst_gap > 0) begin
                dst_gap--;
                rdy = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                dst_gap = $urandom_range(0, 2);
                rdy = 1'b0;
            end
            m_tready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("eased_tween_table_test NOT OK");
            $finish;
        end
    end

    function automatic t_order mk(logic [2:0] cmd, logic [15:0] delta, logic [31:0] sv,
                                  logic [31:0] ev, logic [23:0] span, logic [3:0] mode,
                                  logic [15:0] tid);
        t_order o;
        o = '{cmd, delta, sv, ev, span, mode, tid};
        return o;
    endfunction

    function automatic t_order rand_start();
        logic [23:0] sp;
        case ($urandom_range(0, 9))
            0: sp = 24'd0;
            1: sp = 24'($urandom);
            2: sp = 24'hFFFFFF;
            default: sp = 24'($urandom_range(1, 3000));
        endcase
        return mk(ett_pkg::CMD_START, 16'($urandom), $urandom, $urandom, sp,
                  4'($urandom_range(0, 15)), 16'($urandom));
    endfunction

    initial begin
        int r;
        foreach (tw_valid[i]) begin
            tw_valid[i] = 1'b0;
            tw_cancel[i] = 1'b0;
        end
        // directed: extremes, every curve, cancels, odd commands
        enqueue(mk(ett_pkg::CMD_TICK, 16'd100, '0, '0, '0, '0, '0));
        enqueue(mk(ett_pkg::CMD_START, '0, 32'h80000000, 32'h7FFFFFFF, 24'd0,
                   ett_pkg::EASE_LINEAR, '0));
        enqueue(mk(ett_pkg::CMD_START, '0, 32'h7FFFFFFF, 32'h80000000, 24'd1, 4'd15,
                   16'hFFFF));
        for (int m = 1; m <= 10; m++)
            enqueue(mk(ett_pkg::CMD_START, '0, 32'hFFF00000, 32'h00345678, 24'd1000,
                       4'(m), '0));
        enqueue(mk(ett_pkg::CMD_CANCEL, '0, '0, '0, '0, '0, 16'd5));
        enqueue(mk(ett_pkg::CMD_CANCEL, '0, '0, '0, '0, '0, 16'd999));
        enqueue(mk(ett_pkg::CMD_TICK, 16'd0, '0, '0, '0, '0, '0));
        enqueue(mk(ett_pkg::CMD_TICK, 16'd333, '0, '0, '0, '0, '0));
        enqueue(mk(ett_pkg::CMD_TICK, 16'd500, '0, '0, '0, '0, '0));
        enqueue(mk(3'd6, 16'hFFFF, '1, '1, '1, '1, '1));
        enqueue(mk(3'd7, '0, '0, '0, '0, '0, '0));
        enqueue(mk(ett_pkg::CMD_TICK, 16'hFFFF, '0, '0, '0, '0, '0));
        enqueue(mk(ett_pkg::CMD_CLEAR, '0, '0, '0, '0, '0, '0));
        enqueue(mk(ett_pkg::CMD_INIT, '0, '0, '0, '0, '0, '0));
        // random: mostly starts and ticks, some cancels and housekeeping
        hold_at = orders.size() + 40;
        for (int n = 0; n < 72; n++) begin
            r = $urandom_range(0, 99);
            if (r < 38) enqueue(rand_start());
            else if (r < 72)
                enqueue(mk(ett_pkg::CMD_TICK, ($urandom_range(0, 9) == 0) ? 16'($urandom)
                           : 16'($urandom_range(0, 600)), $urandom, $urandom,
                           24'($urandom), 4'($urandom), 16'($urandom)));
            else if (r < 86)
                enqueue(mk(ett_pkg::CMD_CANCEL, '0, '0, '0, '0, '0,
                           ($urandom_range(0, 3) == 0) ? 16'($urandom)
                           : 16'($urandom_range(1, 50))));
            else if (r < 90) enqueue(mk(ett_pkg::CMD_CANCEL_ALL, '0, '0, '0, '0, '0, '0));
            else if (r < 94) enqueue(mk(ett_pkg::CMD_CLEAR, '0, '0, '0, '0, '0, '0));
            else if (r < 97) enqueue(mk(ett_pkg::CMD_INIT, '0, '0, '0, '0, '0, '0));
            else enqueue(mk(3'($urandom_range(6, 7)), 16'($urandom), $urandom,
                            $urandom, 24'($urandom), 4'($urandom), 16'($urandom)));
        end
        for (int n = 0; n < 16; n++) enqueue(rand_start());
        for (int n = 0; n < 8; n++)
            enqueue(mk(ett_pkg::CMD_TICK, 16'($urandom_range(0, 2000)), '0, '0, '0, '0, '0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (orders.size() != 0 || s_tvalid || expected_events.size() != 0);
        repeat (500) @(posedge i_clk);
        if (errors == 0 && expected_events.size() == 0) begin
            $display("eased_tween_table_test OK");
        end else begin
            $display("eased_tween_table_test NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire
